// File: rtl/eeg_pkg.sv
// ---------------------------------------------------------------------------
// eeg_pkg
// Shared constants for the exponential ElGamal engine: widths, operation
// codes, register indexes and register reset values.
// ---------------------------------------------------------------------------
package eeg_pkg;

  // default modulus width and fixed field widths
  localparam int MOD_WIDTH_DEF = 32;
  localparam int REG_WIDTH     = 32;
  localparam int EXP_WIDTH     = 32;
  localparam int CFG_IDX_WIDTH = 2;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GENERATOR  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PUBLIC_KEY = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SECRET_KEY = 2'd3;

  // register reset values
  localparam logic [REG_WIDTH-1:0] MODULUS_RST    = 32'd2207;
  localparam logic [REG_WIDTH-1:0] GENERATOR_RST  = 32'd1425;
  localparam logic [REG_WIDTH-1:0] PUBLIC_KEY_RST = 32'd1;
  localparam logic [REG_WIDTH-1:0] SECRET_KEY_RST = 32'd0;

endpackage

// File: rtl/exponential_elgamal_engine.sv
// ---------------------------------------------------------------------------
// exponential_elgamal_engine
// Exponential ElGamal encrypt/decrypt over Z/p, built on a bit-serial modular
// multiplier and a bit-serial divider driven by one sequencer.
// ---------------------------------------------------------------------------
// One item at a time; a new item waits until the last result is registered.
// Encrypt: three 32-bit exponentiations plus one multiply.
// Decrypt: one exponentiation, an extended Euclid inversion with one divide
//   and one multiply per step, then a final multiply.
// Synchronous active-low reset restores the register reset values and idles.
module exponential_elgamal_engine #(
  parameter int MOD_WIDTH = eeg_pkg::MOD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [eeg_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [eeg_pkg::REG_WIDTH-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic [31:0]                           in_message,
  input  logic [31:0]                           in_nonce,
  input  logic [31:0]                           in_cipher_first,
  input  logic [31:0]                           in_cipher_second,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [31:0]                           out_result_first,
  output logic [31:0]                           out_result_second,
  output logic                                  out_fault
);

  localparam int W  = MOD_WIDTH;
  localparam int EW = eeg_pkg::EXP_WIDTH;
  localparam int CW = $clog2(EW + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MWAIT  = 5'd1;
  localparam logic [4:0] S_PW_RED = 5'd2;
  localparam logic [4:0] S_PW_INI = 5'd3;
  localparam logic [4:0] S_PW_SQ  = 5'd4;
  localparam logic [4:0] S_PW_MU  = 5'd5;
  localparam logic [4:0] S_PW_NX  = 5'd6;
  localparam logic [4:0] S_E1     = 5'd7;
  localparam logic [4:0] S_E2     = 5'd8;
  localparam logic [4:0] S_E3     = 5'd9;
  localparam logic [4:0] S_E4     = 5'd10;
  localparam logic [4:0] S_D1     = 5'd11;
  localparam logic [4:0] S_DLOOP  = 5'd12;
  localparam logic [4:0] S_DDIVW  = 5'd13;
  localparam logic [4:0] S_DT     = 5'd14;
  localparam logic [4:0] S_DFIN   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  // mask a register value to the modulus width
  function automatic logic [W-1:0] to_w(input logic [31:0] v);
    logic [63:0] x;
    x = 64'(v);
    return x[W-1:0];
  endfunction

  // widen a residue back to 32 bits, dropping bits above
  function automatic logic [31:0] to_32(input logic [W-1:0] v);
    logic [63:0] x;
    x = 64'(v);
    return x[31:0];
  endfunction

  logic [31:0]   mod_r, gen_r, pk_r, sk_r;
  logic [4:0]    state_r, mret_r, pret_r;
  logic [31:0]   msg_r, non_r;
  logic [W-1:0]  c2_r, p_r, mres_r;
  logic [W-1:0]  pb_r, pacc_r, tmp_r;
  logic [EW-1:0] pe_r;
  logic [CW-1:0] pc_r;
  logic [W-1:0]  r0_r, r1_r, t0_r, t1_r;
  logic [W-1:0]  res1_r, res2_r;
  logic          flt_r;
  logic          ov_r;
  logic [31:0]   of_r, os_r;
  logic          oflt_r;

  logic          mul_go, mul_done, div_go, div_done;
  logic [W-1:0]  mul_a, mul_b, mul_p, div_q, div_r;
  logic [4:0]    mul_ret;
  logic [W-1:0]  p_in;
  logic          in_xfer;

  assign p_in     = to_w(mod_r);
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= eeg_pkg::MODULUS_RST;
      gen_r <= eeg_pkg::GENERATOR_RST;
      pk_r  <= eeg_pkg::PUBLIC_KEY_RST;
      sk_r  <= eeg_pkg::SECRET_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        eeg_pkg::REG_MODULUS:    mod_r <= cfg_data;
        eeg_pkg::REG_GENERATOR:  gen_r <= cfg_data;
        eeg_pkg::REG_PUBLIC_KEY: pk_r  <= cfg_data;
        eeg_pkg::REG_SECRET_KEY: sk_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // issue multiplies and divides for the current step
  always_comb begin
    mul_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_ret = S_IDLE;
    div_go  = 1'b0;
    case (state_r)
      S_PW_RED: begin
        mul_go = 1'b1; mul_a = W'(1); mul_b = pb_r; mul_ret = S_PW_INI;
      end
      S_PW_SQ: begin
        if (pc_r != '0) begin
          mul_go = 1'b1; mul_a = pacc_r; mul_b = pacc_r; mul_ret = S_PW_MU;
        end
      end
      S_PW_MU: begin
        if (pe_r[EW-1]) begin
          mul_go = 1'b1; mul_a = mres_r; mul_b = pb_r; mul_ret = S_PW_NX;
        end
      end
      S_E3: begin
        mul_go = 1'b1; mul_a = tmp_r; mul_b = pacc_r; mul_ret = S_E4;
      end
      S_DLOOP: begin
        if (r1_r == '0) begin
          if (r0_r == W'(1)) begin
            mul_go = 1'b1; mul_a = t0_r; mul_b = c2_r; mul_ret = S_DFIN;
          end
        end else begin
          div_go = 1'b1;
        end
      end
      S_DDIVW: begin
        if (div_done) begin
          mul_go = 1'b1; mul_a = t1_r; mul_b = div_q; mul_ret = S_DT;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != S_DONE) ov_r <= 1'b0;
      if (mul_go) begin
        state_r <= S_MWAIT;
        mret_r  <= mul_ret;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            msg_r <= in_message;
            non_r <= in_nonce;
            c2_r  <= to_w(in_cipher_second);
            p_r   <= p_in;
            if (p_in < W'(2)) begin
              // every residue is zero: encrypt gives zeros, decrypt faults
              res1_r  <= '0;
              res2_r  <= '0;
              flt_r   <= in_operation;
              state_r <= S_DONE;
            end else if (in_operation == eeg_pkg::OP_ENCRYPT) begin
              pb_r    <= to_w(gen_r);
              pe_r    <= in_nonce;
              pret_r  <= S_E1;
              state_r <= S_PW_RED;
            end else begin
              pb_r    <= to_w(in_cipher_first);
              pe_r    <= to_32(to_w(sk_r));
              pret_r  <= S_D1;
              state_r <= S_PW_RED;
            end
          end
        end
        S_MWAIT: begin
          if (mul_done) begin
            mres_r  <= mul_p;
            state_r <= mret_r;
          end
        end
        // multiply issued above; wait for it
        S_PW_RED, S_E3: ;
        S_PW_INI: begin
          pb_r    <= mres_r;
          pacc_r  <= W'(1);
          pc_r    <= CW'(EW);
          state_r <= S_PW_SQ;
        end
        S_PW_SQ: begin
          if (pc_r == '0) state_r <= pret_r;
        end
        S_PW_MU: begin
          pacc_r <= mres_r;
          pe_r   <= {pe_r[EW-2:0], 1'b0};
          pc_r   <= pc_r - 1'b1;
          if (!pe_r[EW-1]) state_r <= S_PW_SQ;
        end
        S_PW_NX: begin
          pacc_r  <= mres_r;
          state_r <= S_PW_SQ;
        end
        S_E1: begin
          res1_r  <= pacc_r;
          pb_r    <= to_w(gen_r);
          pe_r    <= msg_r;
          pret_r  <= S_E2;
          state_r <= S_PW_RED;
        end
        S_E2: begin
          tmp_r   <= pacc_r;
          pb_r    <= to_w(pk_r);
          pe_r    <= non_r;
          pret_r  <= S_E3;
          state_r <= S_PW_RED;
        end
        S_E4: begin
          res2_r  <= mres_r;
          flt_r   <= 1'b0;
          state_r <= S_DONE;
        end
        S_D1: begin
          r0_r    <= p_r;
          r1_r    <= pacc_r;
          t0_r    <= '0;
          t1_r    <= W'(1);
          state_r <= S_DLOOP;
        end
        S_DLOOP: begin
          if (div_go) begin
            state_r <= S_DDIVW;
          end else if (r0_r != W'(1)) begin
            // gcd is not one: no inverse
            res1_r  <= '0;
            res2_r  <= '0;
            flt_r   <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DDIVW: begin
          if (div_done) begin
            r0_r <= r1_r;
            r1_r <= div_r;
          end
        end
        S_DT: begin
          // t1 <- t0 - q*t1 mod p
          t0_r    <= t1_r;
          t1_r    <= (t0_r >= mres_r) ? t0_r - mres_r : t0_r + (p_r - mres_r);
          state_r <= S_DLOOP;
        end
        S_DFIN: begin
          res1_r  <= mres_r;
          res2_r  <= '0;
          flt_r   <= 1'b0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!ov_r || out_ready) begin
            ov_r    <= 1'b1;
            of_r    <= to_32(res1_r);
            os_r    <= to_32(res2_r);
            oflt_r  <= flt_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  eeg_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .m     (p_r),
    .done  (mul_done),
    .prod  (mul_p)
  );

  eeg_moddiv #(.MOD_WIDTH(MOD_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .n     (r0_r),
    .d     (r1_r),
    .done  (div_done),
    .quot  (div_q),
    .rem   (div_r)
  );

  assign out_valid         = ov_r;
  assign out_result_first  = of_r;
  assign out_result_second = os_r;
  assign out_fault         = oflt_r;

endmodule

// File: rtl/eeg_modmul.sv
// ---------------------------------------------------------------------------
// eeg_modmul
// Bit-serial modular multiplier: prod = a * b mod m, one bit of b per cycle,
// most significant first. Needs a < m; b may be any value.
// ---------------------------------------------------------------------------
module eeg_modmul #(
  parameter int MOD_WIDTH = eeg_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] a,
  input  logic [MOD_WIDTH-1:0] b,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] prod
);

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_r, b_r, m_r, acc_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    dbl, dbl_red, sum;
  logic [W-1:0]  acc_nxt;

  // double, reduce, add the partial product, reduce
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = dbl_red + (b_r[W-1] ? {1'b0, a_r} : '0);
    acc_nxt = (sum >= {1'b0, m_r}) ? W'(sum - {1'b0, m_r}) : sum[W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: rtl/eeg_moddiv.sv
// ---------------------------------------------------------------------------
// eeg_moddiv
// Bit-serial restoring divider: quot = n / d, rem = n % d, one quotient bit
// per cycle. Needs d != 0.
// ---------------------------------------------------------------------------
module eeg_moddiv #(
  parameter int MOD_WIDTH = eeg_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] n,
  input  logic [MOD_WIDTH-1:0] d,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] quot,
  output logic [MOD_WIDTH-1:0] rem
);

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  n_r, d_r, rem_r, q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial;
  logic          qbit;

  // shift in the next dividend bit and trial-subtract
  always_comb begin
    trial = {rem_r, n_r[W-1]};
    qbit  = (trial >= {1'b0, d_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n;
      d_r   <= d;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[W-2:0], 1'b0};
      rem_r <= qbit ? W'(trial - {1'b0, d_r}) : trial[W-1:0];
      q_r   <= {q_r[W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule
